@@ design/nsr_pkg.sv @@
// shared constants, microcode field codes and control/status structs
// for the newton square root block; no dependencies
`default_nettype none

package nsr_pkg;

   localparam int FRAC_BITS = 16;
   localparam int MAX_ITERS = 32;

   localparam int RAD_W  = 14;
   localparam int ROOT_W = 23;
   localparam int CUR_W  = 10 + FRAC_BITS;
   localparam int Q_W    = CUR_W + 1;
   localparam int NUM_W  = RAD_W + 2 * FRAC_BITS;
   localparam int ITER_W = $clog2(MAX_ITERS + 1);
   localparam int DCNT_W = $clog2(Q_W);
   localparam int PC_W   = 3;

   localparam logic [RAD_W-1:0] RADICAND_MAX = RAD_W'(10000);

   // datapath operations
   localparam logic [2:0] OP_WAIT   = 3'd0;
   localparam logic [2:0] OP_CHECK  = 3'd1;
   localparam logic [2:0] OP_DIV    = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_EMIT   = 3'd4;
   localparam logic [2:0] OP_NOP    = 3'd5;

   // jump conditions
   localparam logic [2:0] C_ALWAYS   = 3'd0;
   localparam logic [2:0] C_NO_REQ   = 3'd1;
   localparam logic [2:0] C_STOP     = 3'd2;
   localparam logic [2:0] C_DIV_MORE = 3'd3;
   localparam logic [2:0] C_DESCENT  = 3'd4;
   localparam logic [2:0] C_OUT_BUSY = 3'd5;

   typedef struct packed {
      logic [2:0] op;
   } ctrl_type;

   typedef struct packed {
      logic accept;
      logic stop;
      logic div_more;
      logic descent;
      logic out_busy;
   } status_type;

endpackage

`default_nettype wire

@@ design/newton_square_root.sv @@
// newton square root: each newton step is a check, a restoring division in the divider and
// an update; the loop stops at the check on a range error, a zero estimate or the iteration
// cap of 32 steps, or at an update that no longer lowers the estimate. one item at a time;
// the next req transfer can happen after the result is loaded and the sequencer has passed
// its nop state back to wait, even while the result is stalled.
// synchronous active-high reset clears the pc, the step and bit counters and the rsp valid flag.
`default_nettype none

module newton_square_root import nsr_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  wire [RAD_W-1:0]   req_radicand,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [ROOT_W-1:0] rsp_root,
   output logic              rsp_range_error
);

   ctrl_type   ctrl;
   status_type status;

   nsr_sequencer u_sequencer (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   nsr_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .ctrl            (ctrl),
      .status          (status),
      .req_valid       (req_valid),
      .req_radicand    (req_radicand),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_root        (rsp_root),
      .rsp_range_error (rsp_range_error)
   );

   assign req_stall = ctrl.op != OP_WAIT;

endmodule

`default_nettype wire

@@ design/nsr_sequencer.sv @@
// microcode rom and step counter with conditional jumps
// depends on nsr_pkg
`default_nettype none

module nsr_sequencer import nsr_pkg::*; (
   input  wire        clock,
   input  wire        reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   typedef struct packed {
      logic [2:0]      op;
      logic [2:0]      cond;
      logic [PC_W-1:0] target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      case (pc)
         PC_W'(0): w = '{op: OP_WAIT,   cond: C_NO_REQ,   target: PC_W'(0)};
         PC_W'(1): w = '{op: OP_CHECK,  cond: C_STOP,     target: PC_W'(4)};
         PC_W'(2): w = '{op: OP_DIV,    cond: C_DIV_MORE, target: PC_W'(2)};
         PC_W'(3): w = '{op: OP_UPDATE, cond: C_DESCENT,  target: PC_W'(1)};
         PC_W'(4): w = '{op: OP_EMIT,   cond: C_OUT_BUSY, target: PC_W'(4)};
         PC_W'(5): w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_W'(0)};
         default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: PC_W'(0)};
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff;
   logic [PC_W-1:0] pc_in;
   ucode_type       word;
   logic            jump;

   always_comb begin
      word = ucode_rom(pc_ff);
      case (word.cond)
         C_ALWAYS:   jump = 1'b1;
         C_NO_REQ:   jump = !status.accept;
         C_STOP:     jump = status.stop;
         C_DIV_MORE: jump = status.div_more;
         C_DESCENT:  jump = status.descent;
         C_OUT_BUSY: jump = status.out_busy;
         default:    jump = 1'b1;
      endcase
      pc_in   = jump ? word.target : pc_ff + PC_W'(1);
      ctrl.op = word.op;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

@@ design/nsr_datapath.sv @@
// estimate, restoring divider, newton update and result register
// depends on nsr_pkg; driven by nsr_sequencer
`default_nettype none

module nsr_datapath import nsr_pkg::*; (
   input  wire               clock,
   input  wire               reset,
   input  ctrl_type          ctrl,
   output status_type        status,
   input  wire               req_valid,
   input  wire [RAD_W-1:0]   req_radicand,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output logic [ROOT_W-1:0] rsp_root,
   output logic              rsp_range_error
);

   function automatic logic [CUR_W-1:0] seed_for(input logic [RAD_W-1:0] n);
      logic [9:0] s;
      if (n < RAD_W'(10))          s = 10'd100;
      else if (n < RAD_W'(100))    s = 10'd200;
      else if (n < RAD_W'(1000))   s = 10'd300;
      else if (n < RADICAND_MAX)   s = 10'd500;
      else                         s = 10'd600;
      return CUR_W'(s) << FRAC_BITS;
   endfunction

   logic [RAD_W-1:0]  n_ff, n_in;
   logic              err_ff, err_in;
   logic [CUR_W-1:0]  cur_ff, cur_in;
   logic [CUR_W-1:0]  rem_ff, rem_in;
   logic [Q_W-1:0]    quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic              rsp_err_ff, rsp_err_in;

   logic [NUM_W-1:0]  num;
   logic [CUR_W:0]    trial;
   logic [CUR_W:0]    diff;
   logic              trial_ge;
   logic [CUR_W+1:0]  sum;
   logic [CUR_W:0]    nxt;

   always_comb begin
      num      = NUM_W'(n_ff) << (2 * FRAC_BITS);
      trial    = {rem_ff, quo_ff[Q_W-1]};
      trial_ge = trial >= {1'b0, cur_ff};
      diff     = trial - {1'b0, cur_ff};
      sum      = {2'b00, cur_ff} + {1'b0, quo_ff};
      nxt      = sum[CUR_W+1:1];

      status.accept   = req_valid && (ctrl.op == OP_WAIT);
      status.stop     = err_ff || (iter_ff == ITER_W'(MAX_ITERS)) || (cur_ff == '0);
      status.div_more = dcnt_ff != DCNT_W'(Q_W - 1);
      status.descent  = nxt < {1'b0, cur_ff};
      status.out_busy = rsp_valid_ff && rsp_stall;

      n_in         = n_ff;
      err_in       = err_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      iter_in      = iter_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_root_in  = rsp_root_ff;
      rsp_err_in   = rsp_err_ff;

      case (ctrl.op)
         OP_WAIT: begin
            if (status.accept) begin
               n_in    = req_radicand;
               err_in  = (req_radicand == '0) || (req_radicand > RADICAND_MAX);
               cur_in  = seed_for(req_radicand);
               iter_in = '0;
            end
         end
         OP_CHECK: begin
            rem_in  = CUR_W'(num[NUM_W-1:Q_W]);
            quo_in  = num[Q_W-1:0];
            dcnt_in = '0;
         end
         OP_DIV: begin
            rem_in  = trial_ge ? diff[CUR_W-1:0] : trial[CUR_W-1:0];
            quo_in  = {quo_ff[Q_W-2:0], trial_ge};
            dcnt_in = dcnt_ff + DCNT_W'(1);
         end
         OP_UPDATE: begin
            if (status.descent) begin
               cur_in  = nxt[CUR_W-1:0];
               iter_in = iter_ff + ITER_W'(1);
            end
         end
         OP_EMIT: begin
            if (!status.out_busy) begin
               rsp_valid_in = 1'b1;
               rsp_root_in  = err_ff ? '0 : ROOT_W'(cur_ff);
               rsp_err_in   = err_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         iter_ff      <= '0;
         dcnt_ff      <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         iter_ff      <= iter_in;
         dcnt_ff      <= dcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      err_ff      <= err_in;
      cur_ff      <= cur_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      rsp_root_ff <= rsp_root_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root        = rsp_root_ff;
   assign rsp_range_error = rsp_err_ff;

`ifndef SYNTHESIS
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_DIV) |-> (rem_ff < cur_ff))
      else $error("partial remainder not below divisor");

   a_estimate_falls: assert property (@(posedge clock) disable iff (reset)
      (ctrl.op == OP_UPDATE && status.descent) |=> (cur_ff < $past(cur_ff)))
      else $error("estimate did not decrease on newton step");

   a_error_root_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_err_ff) |-> (rsp_root_ff == '0))
      else $error("range error with nonzero root");

   a_iter_cap: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(MAX_ITERS))
      else $error("iteration count past cap");
`endif

endmodule

`default_nettype wire
